[rtl/core/rrbm_pkg.sv]
// ----------------------------------------------------------------------------
// rrbm_pkg: shared constants and types for the bank mapper
// Address map bounds, bank geometry and the decoded access record.
// ----------------------------------------------------------------------------
package rrbm_pkg;

    // Bank geometry
    localparam int RAM_BANKS      = 8;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int STORE_BYTES    = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW         = $clog2(STORE_BYTES);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);

    // Field widths
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_BANK_W = 8;
    localparam int RAM_BANK_W = 3;
    localparam int ROM_ADDR_W = 22;

    // Address map bounds
    localparam logic [ADDR_W-1:0] RAM_EN_LAST   = 16'h1FFF;
    localparam logic [ADDR_W-1:0] ROM_BANK_LAST = 16'h3FFF;
    localparam logic [ADDR_W-1:0] RAM_BANK_LAST = 16'h5FFF;
    localparam logic [ADDR_W-1:0] ROM_LAST      = 16'h7FFF;
    localparam logic [ADDR_W-1:0] EXT_RAM_FIRST = 16'hA000;
    localparam logic [ADDR_W-1:0] EXT_RAM_LAST  = 16'hBFFF;

    // Register write values
    localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [DATA_W-1:0] RAM_BANK_MAX   = 8'h07;
    localparam logic [DATA_W:0]   RAM_BANKS_LIM  = (DATA_W+1)'(RAM_BANKS);

    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    // Decoded access, decode stage to pipeline
    typedef struct packed {
        logic                  ram_we;
        logic                  ram_re;
        logic [RAM_AW-1:0]     ram_addr;
        logic [DATA_W-1:0]     wdata;
        logic                  rom_access;
        logic [ROM_ADDR_W-1:0] rom_address;
    } t_access;

endpackage

[rtl/core/rrbm_if.sv]
// ----------------------------------------------------------------------------
// rrbm_if: valid/ready channels of the bank mapper
// Bus access channel in, result channel out.
// ----------------------------------------------------------------------------
interface rrbm_in_if;
    import rrbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

interface rrbm_out_if;
    import rrbm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [DATA_W-1:0]     read_data;
    logic                  rom_access;
    logic [ROM_ADDR_W-1:0] rom_address;

    modport source (output valid, output read_data, output rom_access,
                    output rom_address, input ready);
    modport sink   (input valid, input read_data, input rom_access,
                    input rom_address, output ready);
endinterface

[rtl/core/rrbm_ram.sv]
// ----------------------------------------------------------------------------
// rrbm_ram: generic single-port synchronous RAM
// One access per cycle, registered read data.
// ----------------------------------------------------------------------------
module rrbm_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/rrbm_decode.sv]
// ----------------------------------------------------------------------------
// rrbm_decode: bank registers and address decode
// Holds RAM enable, ROM bank and RAM bank; maps each access.
// ----------------------------------------------------------------------------
module rrbm_decode
    import rrbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    output t_access           o_access
);
    logic                  r_ram_enabled;
    logic [ROM_BANK_W-1:0] r_rom_bank;
    logic [RAM_BANK_W-1:0] r_ram_bank;

    logic is_write;
    logic in_ext_ram;

    assign is_write   = (i_kind == KIND_WRITE);
    assign in_ext_ram = (i_address >= EXT_RAM_FIRST) && (i_address <= EXT_RAM_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enabled <= 1'b0;
            r_rom_bank    <= ROM_BANK_W'(1);
            r_ram_bank    <= '0;
        end else if (i_accept && is_write) begin
            if (i_address <= RAM_EN_LAST) begin
                r_ram_enabled <= (i_write_data == RAM_ENABLE_KEY);
            end else if (i_address <= ROM_BANK_LAST) begin
                r_rom_bank <= (i_write_data == '0) ? ROM_BANK_W'(1) : i_write_data;
            end else if (i_address <= RAM_BANK_LAST) begin
                if (i_write_data <= RAM_BANK_MAX &&
                    {1'b0, i_write_data} < RAM_BANKS_LIM) begin
                    r_ram_bank <= i_write_data[RAM_BANK_W-1:0];
                end
            end
        end
    end

    always_comb begin
        o_access.ram_we      = is_write && in_ext_ram && r_ram_enabled;
        o_access.ram_re      = !is_write && in_ext_ram && r_ram_enabled;
        o_access.ram_addr    = RAM_AW'({r_ram_bank, i_address[RAM_OFS_W-1:0]});
        o_access.wdata       = i_write_data;
        o_access.rom_access  = 1'b0;
        o_access.rom_address = '0;
        if (!is_write) begin
            if (i_address <= ROM_BANK_LAST) begin
                o_access.rom_access  = 1'b1;
                o_access.rom_address = ROM_ADDR_W'(i_address);
            end else if (i_address <= ROM_LAST) begin
                o_access.rom_access  = 1'b1;
                o_access.rom_address = {r_rom_bank, i_address[ROM_OFS_W-1:0]};
            end
        end
    end
endmodule

[rtl/core/rom_ram_bank_mapper_core.sv]
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_core: cartridge ROM/RAM bank controller
// Bank registers, banked external RAM in a synchronous memory, ROM mapping.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              handshake
//  i_in     in   kind, address, write_data            valid/ready
//  o_out    out  read_data, rom_access, rom_address   valid/ready
//
//  One item per cycle sustained while o_out is ready; accepted items reach
//  o_out.valid through the RAM read port, then the output register.
//  After reset a clearing pass writes zero to all STORE_BYTES RAM entries,
//  one per cycle (65536 entries at eight banks); i_in.ready stays low meanwhile.
//  A stall on o_out backs up through the stage register to i_in.ready.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_core
    import rrbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrbm_in_if.sink     i_in,
    rrbm_out_if.source  o_out
);
    t_access acc;
    logic    accept;
    logic    s1_move;

    // Clearing sweep
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;

    // Stage 1: RAM read in flight
    logic                  r_s1_valid;
    logic                  r_s1_ram;
    logic                  r_s1_rom_access;
    logic [ROM_ADDR_W-1:0] r_s1_rom_address;

    // Output register
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_read_data;
    logic                  r_out_rom_access;
    logic [ROM_ADDR_W-1:0] r_out_rom_address;

    // RAM port
    logic              ram_we;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign s1_move    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || s1_move);
    assign accept     = i_in.valid && i_in.ready;

    rrbm_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_in.kind),
        .i_address    (i_in.address),
        .i_write_data (i_in.write_data),
        .o_access     (acc)
    );

    // Sweep owns the port while clearing; no item is accepted then.
    // A write lands at the accept edge, so a read one item later sees it.
    assign ram_we    = r_clr_busy || (accept && acc.ram_we);
    assign ram_re    = accept && acc.ram_re;
    assign ram_addr  = r_clr_busy ? r_clr_addr : acc.ram_addr;
    assign ram_wdata = r_clr_busy ? '0 : acc.wdata;

    rrbm_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (RAM_AW),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RAM_AW'(STORE_BYTES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload, no reset
        if (accept) begin
            r_s1_ram         <= acc.ram_re;
            r_s1_rom_access  <= acc.rom_access;
            r_s1_rom_address <= acc.rom_address;
        end
        // ram_rdata holds while s1 stalls: reads issue only on accept
        if (s1_move) begin
            r_out_read_data   <= r_s1_ram ? ram_rdata : '0;
            r_out_rom_access  <= r_s1_rom_access;
            r_out_rom_address <= r_s1_rom_address;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_out_read_data;
    assign o_out.rom_access  = r_out_rom_access;
    assign o_out.rom_address = r_out_rom_address;

    // No item taken while the sweep runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && i_in.valid && i_in.ready))
        else $error("item accepted during RAM clearing pass");

    // A stalled stage item is neither dropped nor replaced
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_rom_address)
                                      && $stable(r_s1_ram)))
        else $error("stage item lost while stalled");

    // A moving stage item is taken into the output register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("stage item did not reach output register");

    // ROM results never carry RAM data
    a_rom_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rom_access) |-> (r_out_read_data == '0))
        else $error("ROM result with nonzero read data");
endmodule
